/* hw/rtl/gsia_pkg.sv */
`timescale 1ns / 1ps
// gsia_pkg: widths, register indexes and datapath command codes for the survey-in accumulator.
// Used by gsia_ctrl, gsia_dp and gnss_survey_in_accumulator. No dependencies.
package gsia_pkg;

    // Field widths
    localparam int POS_W   = 37;
    localparam int N_W     = 16;
    localparam int SUM_W   = 41;
    localparam int SQ_W    = 64;
    localparam int MAG_W   = 41;
    localparam int PROD_W  = 82;
    localparam int TOT_W   = 84;
    localparam int DVSR_W  = 32;
    localparam int REM_W   = 33;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SREM_W  = 34;
    localparam int ACC_W   = 25;
    localparam int MOBS_W  = 16;
    localparam int MEANQ_W = 42;
    localparam int CNT_W   = 7;
    localparam int AXES    = 3;

    // Stream widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 160;
    localparam int CFG_W      = 25;

    // Parameter defaults
    localparam int COUNT_MAX_DEF   = 65535;
    localparam int OFFSET_BITS_DEF = 25;

    // Register reset values
    localparam logic [MOBS_W-1:0] MIN_OBS_RST   = MOBS_W'(60);
    localparam logic [ACC_W-1:0]  ACC_LIMIT_RST = ACC_W'(20000);

    // Iteration counts (last step index)
    localparam logic [CNT_W-1:0] NSQ_LAST  = CNT_W'(N_W - 1);
    localparam logic [CNT_W-1:0] SS_LAST   = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] VAR_LAST  = CNT_W'(TOT_W - 1);
    localparam logic [CNT_W-1:0] MEAN_LAST = CNT_W'(MEANQ_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_MIN_OBS   = 1'b0,
        REG_ACC_LIMIT = 1'b1
    } reg_idx_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQACC,
        OP_MUL_LD_NSQ,
        OP_MUL_LD_SS,
        OP_MUL_STEP,
        OP_ACCUM,
        OP_DIV_LD_VAR,
        OP_DIV_LD_MEAN,
        OP_DIV_STEP,
        OP_SQRT_LD,
        OP_SQRT_STEP,
        OP_SQRT_END,
        OP_MEAN_END,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_lt2;
    } status_t;

endpackage

/* hw/rtl/gsia_ctrl.sv */
`timescale 1ns / 1ps
// gsia_ctrl: sequencer for the survey-in accumulator; steps the shared multiplier,
// divider and root units. Depends on gsia_pkg.
module gsia_ctrl
    import gsia_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQACC,
        ST_NSQ_LD,
        ST_NSQ_RUN,
        ST_SS_LD,
        ST_SS_RUN,
        ST_ACCUM,
        ST_VAR_LD,
        ST_VAR_RUN,
        ST_SQRT_LD,
        ST_SQRT_RUN,
        ST_SQRT_END,
        ST_MEAN_LD,
        ST_MEAN_RUN,
        ST_MEAN_END,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [1:0]       axis_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ready_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign in_ready  = ready_reg;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Command decode
    always_comb
    begin
        cmd.axis = axis_reg;
        case (state_reg)
            ST_SQACC:    cmd.op = OP_SQACC;
            ST_NSQ_LD:   cmd.op = OP_MUL_LD_NSQ;
            ST_NSQ_RUN:  cmd.op = OP_MUL_STEP;
            ST_SS_LD:    cmd.op = OP_MUL_LD_SS;
            ST_SS_RUN:   cmd.op = OP_MUL_STEP;
            ST_ACCUM:    cmd.op = OP_ACCUM;
            ST_VAR_LD:   cmd.op = OP_DIV_LD_VAR;
            ST_VAR_RUN:  cmd.op = OP_DIV_STEP;
            ST_SQRT_LD:  cmd.op = OP_SQRT_LD;
            ST_SQRT_RUN: cmd.op = OP_SQRT_STEP;
            ST_SQRT_END: cmd.op = OP_SQRT_END;
            ST_MEAN_LD:  cmd.op = OP_DIV_LD_MEAN;
            ST_MEAN_RUN: cmd.op = OP_DIV_STEP;
            ST_MEAN_END: cmd.op = OP_MEAN_END;
            ST_FINISH:   cmd.op = out_free ? OP_OUT_LOAD : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            cnt_reg       <= '0;
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Result valid: set on load, cleared when taken
            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        ready_reg <= 1'b0;
                        axis_reg  <= 2'd0;
                        state_reg <= ST_SQACC;
                    end
                end
                ST_SQACC:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= ST_NSQ_LD;
                    end
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                ST_NSQ_LD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_NSQ_RUN;
                end
                ST_NSQ_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == NSQ_LAST)
                        state_reg <= ST_SS_LD;
                end
                ST_SS_LD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SS_RUN;
                end
                ST_SS_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SS_LAST)
                        state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg <= 2'd0;
                        if (status.n_zero)
                            state_reg <= ST_FINISH;
                        else if (status.n_lt2)
                            state_reg <= ST_MEAN_LD;
                        else
                            state_reg <= ST_VAR_LD;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_NSQ_LD;
                    end
                end
                ST_VAR_LD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_VAR_RUN;
                end
                ST_VAR_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == VAR_LAST)
                        state_reg <= ST_SQRT_LD;
                end
                ST_SQRT_LD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT_RUN;
                end
                ST_SQRT_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= ST_SQRT_END;
                end
                ST_SQRT_END:
                begin
                    axis_reg  <= 2'd0;
                    state_reg <= ST_MEAN_LD;
                end
                ST_MEAN_LD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MEAN_RUN;
                end
                ST_MEAN_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == MEAN_LAST)
                        state_reg <= ST_MEAN_END;
                end
                ST_MEAN_END:
                begin
                    if (axis_reg == 2'd2)
                        state_reg <= ST_FINISH;
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MEAN_LD;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/gsia_dp.sv */
`timescale 1ns / 1ps
// gsia_dp: survey state, configuration registers, bit-serial multiplier, divider,
// square root and the output register. Depends on gsia_pkg.
module gsia_dp
    import gsia_pkg::*;
#(
    parameter int COUNT_MAX   = COUNT_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    accept,
    input  logic                    func,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic [OUT_DATA_W-1:0]   out_data
);

    localparam int DIFF_W = POS_W + 1;
    localparam int MSUM_W = POS_W + 7;
    localparam logic signed [DIFF_W-1:0] LIM =
        DIFF_W'((64'd1 << (OFFSET_BITS - 1)) - 64'd1);
    localparam logic [N_W-1:0] N_FULL = N_W'(COUNT_MAX);
    localparam logic signed [MSUM_W-1:0] MEAN_MAX = MSUM_W'((64'd1 << (POS_W - 1)) - 64'd1);
    localparam logic signed [MSUM_W-1:0] MEAN_MIN = -MEAN_MAX - MSUM_W'(1);
    localparam logic [ROOT_W-1:0] ACC_MAX_R = ROOT_W'((64'd1 << ACC_W) - 64'd1);

    // Survey state
    logic                          origin_set_reg;
    logic signed [POS_W-1:0]       origin_reg [AXES];
    logic signed [SUM_W-1:0]       sum_reg [AXES];
    logic [SQ_W-1:0]               sq_reg [AXES];
    logic [N_W-1:0]                n_reg;
    logic                          clip_reg;
    logic signed [OFFSET_BITS-1:0] d_reg [AXES];

    // Config
    logic [MOBS_W-1:0] min_obs_reg;
    logic [ACC_W-1:0]  acc_limit_reg;

    // Arithmetic units
    logic [PROD_W-1:0]       mcand_reg;
    logic [MAG_W-1:0]        mplier_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       nsq_reg;
    logic [TOT_W-1:0]        total_reg;
    logic [TOT_W-1:0]        dvd_reg;
    logic [TOT_W-1:0]        quo_reg;
    logic [DVSR_W-1:0]       dvsr_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [SREM_W-1:0]       srem_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [POS_W-1:0] mean_reg [AXES];
    logic [OUT_DATA_W-1:0]   out_reg;

    // Per-lane offset from origin, clamped
    logic signed [POS_W-1:0]       pos [AXES];
    logic signed [OFFSET_BITS-1:0] d_new [AXES];
    logic [AXES-1:0]               lane_clip;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        for (int a = 0; a < AXES; a++)
        begin
            diff = origin_set_reg ? (DIFF_W'(pos[a]) - DIFF_W'(origin_reg[a])) : '0;
            lane_clip[a] = 1'b0;
            if (diff > LIM)
            begin
                diff = LIM;
                lane_clip[a] = 1'b1;
            end
            else if (diff < -LIM)
            begin
                diff = -LIM;
                lane_clip[a] = 1'b1;
            end
            d_new[a] = diff[OFFSET_BITS-1:0];
        end
    end

    // Selected-axis helpers
    logic signed [SUM_W-1:0]         sum_sel;
    logic [MAG_W-1:0]                mag_sel;
    logic signed [2*OFFSET_BITS-1:0] d_sq;
    logic [REM_W:0]                  div_sh;
    logic [REM_W:0]                  div_diff;
    logic [SREM_W+1:0]               sq_sh;
    logic [SREM_W+1:0]               sq_trial;
    logic [MEANQ_W-1:0]              mean_q;
    logic signed [MSUM_W-1:0]        mean_sum;
    logic signed [POS_W-1:0]         mean_sat;
    logic                            complete;

    assign sum_sel  = sum_reg[cmd.axis];
    assign mag_sel  = sum_sel[SUM_W-1] ? MAG_W'(-sum_sel) : MAG_W'(sum_sel);
    assign d_sq     = d_reg[cmd.axis] * d_reg[cmd.axis];
    assign div_sh   = {rem_reg, dvd_reg[TOT_W-1]};
    assign div_diff = div_sh - (REM_W+1)'(dvsr_reg);
    assign sq_sh    = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial = (SREM_W+2)'({root_reg, 2'b01});
    assign mean_q   = quo_reg[MEANQ_W-1:0];
    assign mean_sum = MSUM_W'(origin_reg[cmd.axis]) +
                      (sum_sel[SUM_W-1] ? -MSUM_W'(mean_q) : MSUM_W'(mean_q));
    assign mean_sat = (mean_sum > MEAN_MAX) ? POS_W'(MEAN_MAX) :
                      (mean_sum < MEAN_MIN) ? POS_W'(MEAN_MIN) : mean_sum[POS_W-1:0];
    assign complete = (n_reg >= min_obs_reg) && (n_reg >= N_W'(2)) &&
                      (acc_reg <= acc_limit_reg);

    assign status.n_zero = (n_reg == '0);
    assign status.n_lt2  = (n_reg < N_W'(2));
    assign out_data      = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_obs_reg   <= MIN_OBS_RST;
            acc_limit_reg <= ACC_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_OBS:   min_obs_reg   <= cfg_data[MOBS_W-1:0];
                REG_ACC_LIMIT: acc_limit_reg <= cfg_data[ACC_W-1:0];
                default:       ;
            endcase
        end
    end

    // Survey state update on accept, square sums per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_set_reg <= 1'b0;
            n_reg          <= '0;
            clip_reg       <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                origin_reg[a] <= '0;
                sum_reg[a]    <= '0;
                sq_reg[a]     <= '0;
                d_reg[a]      <= '0;
            end
        end
        else if (accept)
        begin
            if (func)
            begin
                origin_set_reg <= 1'b0;
                n_reg          <= '0;
                clip_reg       <= 1'b0;
                for (int a = 0; a < AXES; a++)
                begin
                    origin_reg[a] <= '0;
                    sum_reg[a]    <= '0;
                    sq_reg[a]     <= '0;
                    d_reg[a]      <= '0;
                end
            end
            else if (n_reg >= N_FULL)
            begin
                clip_reg <= 1'b1;
                for (int a = 0; a < AXES; a++)
                    d_reg[a] <= '0;
            end
            else
            begin
                origin_set_reg <= 1'b1;
                n_reg          <= n_reg + N_W'(1);
                if (|lane_clip)
                    clip_reg <= 1'b1;
                for (int a = 0; a < AXES; a++)
                begin
                    if (!origin_set_reg)
                        origin_reg[a] <= pos[a];
                    sum_reg[a] <= sum_reg[a] + SUM_W'(d_new[a]);
                    d_reg[a]   <= d_new[a];
                end
            end
        end
        else if (cmd.op == OP_SQACC)
            sq_reg[cmd.axis] <= sq_reg[cmd.axis] + SQ_W'(unsigned'(d_sq));
    end

    // Multiplier, divider, root and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            total_reg <= '0;
            acc_reg   <= '0;
            for (int a = 0; a < AXES; a++)
                mean_reg[a] <= '0;
        end
        case (cmd.op)
            OP_MUL_LD_NSQ:
            begin
                mcand_reg  <= PROD_W'(sq_reg[cmd.axis]);
                mplier_reg <= MAG_W'(n_reg);
                prod_reg   <= '0;
            end
            OP_MUL_LD_SS:
            begin
                nsq_reg    <= prod_reg;
                mcand_reg  <= PROD_W'(mag_sel);
                mplier_reg <= mag_sel;
                prod_reg   <= '0;
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            OP_ACCUM:
            begin
                if (nsq_reg >= prod_reg)
                    total_reg <= total_reg + TOT_W'(nsq_reg - prod_reg);
            end
            OP_DIV_LD_VAR:
            begin
                dvd_reg  <= total_reg;
                dvsr_reg <= DVSR_W'(n_reg * n_reg);
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            OP_DIV_LD_MEAN:
            begin
                dvd_reg  <= {MEANQ_W'({mag_sel, 1'b0}) + MEANQ_W'(n_reg),
                             (TOT_W-MEANQ_W)'(0)};
                dvsr_reg <= DVSR_W'({n_reg, 1'b0});
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                if (div_sh >= (REM_W+1)'(dvsr_reg))
                begin
                    rem_reg <= div_diff[REM_W-1:0];
                    quo_reg <= {quo_reg[TOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_sh[REM_W-1:0];
                    quo_reg <= {quo_reg[TOT_W-2:0], 1'b0};
                end
                dvd_reg <= dvd_reg << 1;
            end
            OP_SQRT_LD:
            begin
                rad_reg  <= (|quo_reg[TOT_W-1:RAD_W]) ? '1 : quo_reg[RAD_W-1:0];
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (sq_sh >= sq_trial)
                begin
                    srem_reg <= SREM_W'(sq_sh - sq_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sq_sh[SREM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_reg <= rad_reg << 2;
            end
            OP_SQRT_END:
                acc_reg <= (root_reg > ACC_MAX_R) ? ACC_MAX_R[ACC_W-1:0] : root_reg[ACC_W-1:0];
            OP_MEAN_END:
                mean_reg[cmd.axis] <= mean_sat;
            OP_OUT_LOAD:
                // fix_count, mean_valid, mean_x, mean_y, mean_z, accuracy, complete, clipped
                out_reg <= {5'b0, clip_reg, complete, acc_reg,
                            mean_reg[2], mean_reg[1], mean_reg[0],
                            !status.n_zero, n_reg};
            default: ;
        endcase
    end

endmodule

/* hw/rtl/gnss_survey_in_accumulator.sv */
`timescale 1ns / 1ps
// gnss_survey_in_accumulator: top level of the survey-in position averager.
// Depends on gsia_pkg, gsia_ctrl and gsia_dp.
//
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         s_axis_tvalid/tready       fix or clear command
//  m_axis    out        m_axis_tvalid/tready       count, mean, accuracy, flags
//  cfg       in         cfg_we                     min_observations, accuracy_limit
//
// A result is loaded once its transaction has passed the bit-serial multiplier (n*sumsq
// and S*S per axis), the 84-step divider for the variance, the 32-step root and one
// 42-step divide per mean axis; one fix held skips the variance and root, none skips all
// divides and the root. The next transaction can be taken in the cycle after the load.
// One transaction is worked at a time; the next is taken while the last result
// still waits in the output register, and a new result waits until that one is taken.
// Reset clears all survey state at once.
module gnss_survey_in_accumulator
    import gsia_pkg::*;
#(
    parameter int COUNT_MAX   = COUNT_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x[36:0], pos_y[73:37], pos_z[110:74]
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // fix_count, mean_valid, mean_x, mean_y,
                                                  // mean_z, accuracy, survey_complete, clipped
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    gsia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    gsia_dp #(
        .COUNT_MAX   (COUNT_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .func      (s_axis_tuser),
        .pos_x     (s_axis_tdata[POS_W-1:0]),
        .pos_y     (s_axis_tdata[2*POS_W-1:POS_W]),
        .pos_z     (s_axis_tdata[3*POS_W-1:2*POS_W]),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule
